// ===== design/sha256_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and the round constant table of the message hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

   // Message bytes taken from one input word at most.
   localparam int BYTES_PER_ITEM = 8;

   // Block geometry and padding layout.
   localparam int BLOCK_BYTES = 64;
   localparam int LEN_OFFSET  = 56;
   localparam int ROUNDS      = 64;
   localparam logic [7:0] PAD_MARK = 8'h80;

   // Eight 32-bit hash words; element 0 is word a (hash word 0).
   typedef logic [7:0][31:0] hash_state_type;

   // Initial hash value.
   localparam hash_state_type HASH_IV = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   // Round constants, indexed by round number.
   localparam logic [31:0] ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // Input word.
   typedef struct packed {
      logic [63:0] data_word;
      logic [3:0]  valid_bytes;
      logic        last;
   } req_type;

   // Result word.
   typedef struct packed {
      logic [63:0] digest_0;
      logic [63:0] digest_1;
      logic [63:0] digest_2;
      logic [63:0] digest_3;
   } rsp_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ABSORB,
      ST_MARK,
      ST_ZERO,
      ST_ROUNDS,
      ST_FOLD,
      ST_DIGEST
   } state_type;

endpackage

// ===== design/sha256_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One compression round and one message schedule step, shared by all rounds.
// ----------------------------------------------------------------------------
module sha256_round (
   input  sha256_pkg::hash_state_type wv_in,
   input  logic [31:0]                w_t,
   input  logic [31:0]                w_t1,
   input  logic [31:0]                w_t9,
   input  logic [31:0]                w_t14,
   input  logic [31:0]                k_t,
   output sha256_pkg::hash_state_type wv_out,
   output logic [31:0]                w_next
);
   import sha256_pkg::*;

   logic [31:0] big_s0;
   logic [31:0] big_s1;
   logic [31:0] choose;
   logic [31:0] major;
   logic [31:0] t1;
   logic [31:0] t2;
   logic [31:0] small_s0;
   logic [31:0] small_s1;

   // Round functions on the working variables.
   assign big_s1 = {wv_in[4][5:0], wv_in[4][31:6]} ^ {wv_in[4][10:0], wv_in[4][31:11]} ^
                   {wv_in[4][24:0], wv_in[4][31:25]};
   assign big_s0 = {wv_in[0][1:0], wv_in[0][31:2]} ^ {wv_in[0][12:0], wv_in[0][31:13]} ^
                   {wv_in[0][21:0], wv_in[0][31:22]};
   assign choose = (wv_in[4] & wv_in[5]) ^ (~wv_in[4] & wv_in[6]);
   assign major  = (wv_in[0] & wv_in[1]) ^ (wv_in[0] & wv_in[2]) ^ (wv_in[1] & wv_in[2]);
   assign t1     = wv_in[7] + big_s1 + choose + k_t + w_t;
   assign t2     = big_s0 + major;

   // Rotate the working variables.
   assign wv_out[0] = t1 + t2;
   assign wv_out[1] = wv_in[0];
   assign wv_out[2] = wv_in[1];
   assign wv_out[3] = wv_in[2];
   assign wv_out[4] = wv_in[3] + t1;
   assign wv_out[5] = wv_in[4];
   assign wv_out[6] = wv_in[5];
   assign wv_out[7] = wv_in[6];

   // Schedule word sixteen places ahead of the current one.
   assign small_s0 = {w_t1[6:0], w_t1[31:7]} ^ {w_t1[17:0], w_t1[31:18]} ^ (w_t1 >> 3);
   assign small_s1 = {w_t14[16:0], w_t14[31:17]} ^ {w_t14[18:0], w_t14[31:19]} ^
                     (w_t14 >> 10);
   assign w_next   = small_s1 + w_t9 + small_s0 + w_t;

endmodule

// ===== design/sha256_message_hasher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Hashes a byte stream of any length; each message ends with a word marked
// last, after which the 256-bit digest is returned and the hash restarts.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Ports                              | Word
//  --------+-----------+------------------------------------+-------------------------
//  req     | in        | req_valid, req_ready, req_data     | up to 8 bytes, last flag
//  rsp     | out       | rsp_valid, rsp_ready, rsp_data     | 256-bit digest
//
//  An input word is accepted, then written into the buffer in one or more inserts;
//  a word that completes a 64-byte block adds its compression (64 rounds on the
//  single round unit, then the fold into the chain value).
//  A last word adds padding inserts, one or two blocks, and the load of the
//  digest, which waits in the output register.
//  req_ready is high only while the sequencer is idle; a stalled digest
//  blocks the sequencer only when the next digest is ready to be loaded.
//  Reset restores the initial hash value and clears the byte and bit counts.
//
module sha256_message_hasher (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sha256_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sha256_pkg::rsp_type rsp_data
);
   import sha256_pkg::*;

   state_type      state_ff;
   state_type      state_in;
   state_type      ret_ff;
   state_type      ret_in;
   state_type      ins_next;
   logic [5:0]     round_ff;
   logic [6:0]     fill_ff;
   logic [63:0]    bitlen_ff;
   logic [3:0]     rem_ff;
   logic [63:0]    data_ff;
   logic           last_ff;
   logic [511:0]   buf_ff;
   hash_state_type wv_ff;
   hash_state_type wv_next;
   hash_state_type chain_ff;
   logic           rsp_valid_ff;
   rsp_type        rsp_data_ff;

   logic           load_item;
   logic           ins_en;
   logic           count_len;
   logic           round_en;
   logic           fold_en;
   logic           emit;
   logic [3:0]     ins_k;
   logic [63:0]    ins_src;
   logic [6:0]     room;
   logic [6:0]     zero_gap;
   logic [6:0]     fill_sum;
   logic           block_full;
   logic [575:0]   ins_shift;
   logic [3:0]     sat_count;
   logic [31:0]    w_next;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Clamp the byte count of an incoming word.
   assign sat_count = (req_data.valid_bytes > 4'(BYTES_PER_ITEM)) ?
                      4'(BYTES_PER_ITEM) : req_data.valid_bytes;

   // Sequencer: next state and control.
   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      ins_next  = ST_IDLE;
      load_item = 1'b0;
      ins_en    = 1'b0;
      count_len = 1'b0;
      round_en  = 1'b0;
      fold_en   = 1'b0;
      emit      = 1'b0;
      ins_k     = '0;
      ins_src   = '0;
      room      = 7'(BLOCK_BYTES) - fill_ff;
      zero_gap  = ((fill_ff <= 7'(LEN_OFFSET)) ? 7'(LEN_OFFSET) : 7'(BLOCK_BYTES)) - fill_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               load_item = 1'b1;
               state_in  = ST_ABSORB;
            end
         end
         ST_ABSORB: begin
            ins_en    = 1'b1;
            count_len = 1'b1;
            ins_src   = data_ff;
            ins_k     = ({3'b000, rem_ff} > room) ? room[3:0] : rem_ff;
            if (rem_ff != ins_k) begin
               ins_next = ST_ABSORB;
            end else if (last_ff) begin
               ins_next = ST_MARK;
            end else begin
               ins_next = ST_IDLE;
            end
         end
         ST_MARK: begin
            ins_en   = 1'b1;
            ins_k    = 4'd1;
            ins_src  = {PAD_MARK, 56'd0};
            ins_next = ST_ZERO;
         end
         ST_ZERO: begin
            ins_en = 1'b1;
            if (zero_gap == 7'd0) begin
               // Zero fill done: the bit length closes the final block.
               ins_k    = 4'd8;
               ins_src  = bitlen_ff;
               ins_next = ST_DIGEST;
            end else begin
               ins_k    = (zero_gap > 7'd8) ? 4'd8 : zero_gap[3:0];
               ins_next = ST_ZERO;
            end
         end
         ST_ROUNDS: begin
            round_en = 1'b1;
            if (round_ff == 6'(ROUNDS - 1)) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            fold_en  = 1'b1;
            state_in = ret_ff;
         end
         ST_DIGEST: begin
            if (!rsp_valid_ff || rsp_ready) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // A full buffer detours through compression, then resumes.
      fill_sum   = fill_ff + {3'b000, ins_k};
      block_full = ins_en && (fill_sum == 7'(BLOCK_BYTES));
      if (ins_en) begin
         if (block_full) begin
            state_in = ST_ROUNDS;
            ret_in   = ins_next;
         end else begin
            state_in = ins_next;
         end
      end
   end

   // Bytes enter at the bottom of the buffer; the first byte ends at the top.
   assign ins_shift = {buf_ff, ins_src} << {ins_k, 3'b000};

   sha256_round u_round (
      .wv_in  (wv_ff),
      .w_t    (buf_ff[511:480]),
      .w_t1   (buf_ff[479:448]),
      .w_t9   (buf_ff[223:192]),
      .w_t14  (buf_ff[63:32]),
      .k_t    (ROUND_K[round_ff]),
      .wv_out (wv_next),
      .w_next (w_next)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         round_ff     <= '0;
         fill_ff      <= '0;
         bitlen_ff    <= '0;
         chain_ff     <= HASH_IV;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         if (round_en) begin
            round_ff <= round_ff + 6'd1;
         end
         if (ins_en) begin
            fill_ff <= block_full ? 7'd0 : fill_sum;
         end
         if (emit) begin
            bitlen_ff <= '0;
         end else if (count_len) begin
            bitlen_ff <= bitlen_ff + {57'd0, ins_k, 3'b000};
         end
         if (emit) begin
            chain_ff <= HASH_IV;
         end else if (fold_en) begin
            for (int i = 0; i < 8; i++) begin
               chain_ff[i] <= chain_ff[i] + wv_ff[i];
            end
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (load_item) begin
         data_ff <= req_data.data_word;
         rem_ff  <= sat_count;
         last_ff <= req_data.last;
      end else if (count_len) begin
         data_ff <= data_ff << {ins_k, 3'b000};
         rem_ff  <= rem_ff - ins_k;
      end
      if (ins_en) begin
         buf_ff <= ins_shift[575:64];
      end else if (round_en) begin
         buf_ff <= {buf_ff[479:0], w_next};
      end
      if (block_full) begin
         wv_ff <= chain_ff;
      end else if (round_en) begin
         wv_ff <= wv_next;
      end
      if (emit) begin
         rsp_data_ff.digest_0 <= {chain_ff[0], chain_ff[1]};
         rsp_data_ff.digest_1 <= {chain_ff[2], chain_ff[3]};
         rsp_data_ff.digest_2 <= {chain_ff[4], chain_ff[5]};
         rsp_data_ff.digest_3 <= {chain_ff[6], chain_ff[7]};
      end
   end

`ifndef SYNTH
   // The buffer count is cleared whenever a block is being compressed.
   a_rounds_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUNDS) |-> (fill_ff == 7'd0))
      else $error("fill count not cleared during compression");

   // The last round always hands over to the fold into the chain value.
   a_rounds_fold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUNDS && round_ff == 6'(ROUNDS - 1)) |=> (state_ff == ST_FOLD))
      else $error("compression did not end in the fold step");

   // A digest is only loaded from the digest state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DIGEST))
      else $error("result loaded outside the digest state");

   // After a digest the next message starts from empty counts.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      emit |=> (bitlen_ff == 64'd0 && fill_ff == 7'd0 && state_ff == ST_IDLE))
      else $error("hash state not restarted after digest");
`endif

endmodule
